>>> sv/sequence_ordered_packet_queue_macros.svh
// Assertion macros used by the sequence-ordered packet queue top level.
`ifndef SEQUENCE_ORDERED_PACKET_QUEUE_MACROS_SVH
`define SEQUENCE_ORDERED_PACKET_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SOQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SOQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/soq_pkg.sv
// Shared constants and codes for the sequence-ordered packet queue.
package soq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int SEQ_BITS_DEF = 16;
    localparam int TAG_BITS_DEF = 16;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_PUSH = 2'd0;
    localparam t_op OP_POP  = 2'd1;
    localparam t_op OP_PEEK = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

>>> sv/sequence_ordered_packet_queue.sv
// Sequence-ordered packet queue: a bounded store kept in ascending sequence order.
// Requests arrive on the input channel (i_in_valid / o_in_stall) with an operation,
// a sequence number and a tag; every request yields exactly one result on the output
// channel (o_out_valid / i_out_stall) with a status, the head entry for pop and peek,
// and the number of entries held afterwards.
// Entries live in a ring inside one memory with a registered read port. A push walks
// from the tail toward the head, one stored entry per cycle, moving each entry whose
// number is equal or higher back by one slot, and writes the new entry into the gap.
// Path from acceptance to the result: a push that is dropped or lands in an empty queue,
// a pop or peek on an empty queue and the unused operation code go straight to the
// finish state; pop and peek otherwise read the head first, and a push into a queue
// that holds entries walks the stored entries before its result is ready. The next
// request is taken the cycle after the result leaves the engine.
// Reset clears the count and the head pointer; the memory is not cleared.
// While the receiver stalls, the result register holds, and the engine can still take
// and finish one more request before it waits for the register to empty.
`include "sequence_ordered_packet_queue_macros.svh"

module sequence_ordered_packet_queue
    import soq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int SEQ_BITS = SEQ_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  t_op                           i_op,
    input  logic [SEQ_BITS-1:0]           i_item_seq,
    input  logic [TAG_BITS-1:0]           i_item_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output t_status                       o_status,
    output logic [SEQ_BITS-1:0]           o_out_seq,
    output logic [TAG_BITS-1:0]           o_out_tag,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W = SEQ_BITS + TAG_BITS;

    logic              w_mem_wr_en;
    logic [IDX_W-1:0]  w_mem_wr_addr;
    logic [DATA_W-1:0] w_mem_wr_data;
    logic              w_mem_rd_en;
    logic [IDX_W-1:0]  w_mem_rd_addr;
    logic [DATA_W-1:0] w_mem_rd_data;

    logic                w_res_valid;
    logic                w_res_take;
    t_status             w_res_status;
    logic [SEQ_BITS-1:0] w_res_seq;
    logic [TAG_BITS-1:0] w_res_tag;
    logic [CNT_W-1:0]    w_res_count;

    logic                r_out_valid, n_out_valid;
    t_status             r_status;
    logic [SEQ_BITS-1:0] r_out_seq;
    logic [TAG_BITS-1:0] r_out_tag;
    logic [CNT_W-1:0]    r_count;

    soq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data),
        .i_rd_en   (w_mem_rd_en),
        .i_rd_addr (w_mem_rd_addr),
        .o_rd_data (w_mem_rd_data)
    );

    soq_ctrl #(
        .CAPACITY (CAPACITY),
        .SEQ_BITS (SEQ_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_item_seq    (i_item_seq),
        .i_item_tag    (i_item_tag),
        .o_mem_wr_en   (w_mem_wr_en),
        .o_mem_wr_addr (w_mem_wr_addr),
        .o_mem_wr_data (w_mem_wr_data),
        .o_mem_rd_en   (w_mem_rd_en),
        .o_mem_rd_addr (w_mem_rd_addr),
        .i_mem_rd_data (w_mem_rd_data),
        .o_res_valid   (w_res_valid),
        .i_res_take    (w_res_take),
        .o_res_status  (w_res_status),
        .o_res_seq     (w_res_seq),
        .o_res_tag     (w_res_tag),
        .o_res_count   (w_res_count)
    );

    // The result register loads when it is empty or is being emptied this cycle.
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_status  <= w_res_status;
            r_out_seq <= w_res_seq;
            r_out_tag <= w_res_tag;
            r_count   <= w_res_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_seq   = r_out_seq;
    assign o_out_tag   = r_out_tag;
    assign o_count     = r_count;

    `SOQ_ASSERT_NOW(a_full_count, o_out_valid && o_status == ST_FULL,
        o_count == CNT_W'(CAPACITY), "dropped push reported with a queue that is not full")
    `SOQ_ASSERT_NOW(a_empty_result, o_out_valid && o_status == ST_EMPTY,
        o_count == '0 && o_out_seq == '0 && o_out_tag == '0,
        "empty result carries entries or data")
    `SOQ_ASSERT_NOW(a_count_bound, o_out_valid, o_count <= CNT_W'(CAPACITY),
        "reported count exceeds capacity")
    `SOQ_ASSERT_NEXT(a_res_hold, w_res_valid && !w_res_take,
        w_res_valid && $stable(w_res_count) && $stable(w_res_status),
        "engine result changed before it was taken")

endmodule

>>> sv/soq_mem.sv
// Entry store: one write port and one registered read port.
module soq_mem
    import soq_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = SEQ_BITS_DEF + TAG_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/soq_ctrl.sv
// Queue sequencer: ring addressing, tail-to-head insertion walk, head pop and peek.
module soq_ctrl
    import soq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int SEQ_BITS = SEQ_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  t_op                           i_op,
    input  logic [SEQ_BITS-1:0]           i_item_seq,
    input  logic [TAG_BITS-1:0]           i_item_tag,
    output logic                          o_mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_wr_addr,
    output logic [SEQ_BITS+TAG_BITS-1:0]  o_mem_wr_data,
    output logic                          o_mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_rd_addr,
    input  logic [SEQ_BITS+TAG_BITS-1:0]  i_mem_rd_data,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output t_status                       o_res_status,
    output logic [SEQ_BITS-1:0]           o_res_seq,
    output logic [TAG_BITS-1:0]           o_res_tag,
    output logic [$clog2(CAPACITY+1)-1:0] o_res_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_EXT = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_HEAD = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Physical slot of a logical position counted from the head, wrapping at the capacity.
    function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= CAP_EXT) begin
            sum = sum - CAP_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [2:0]          r_state,  n_state;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [IDX_W-1:0]    r_head,   n_head;
    logic [IDX_W-1:0]    r_walk,   n_walk;
    logic [SEQ_BITS-1:0] r_seq,    n_seq;
    logic [TAG_BITS-1:0] r_tag,    n_tag;
    t_op                 r_op,     n_op;
    t_status             r_status, n_status;
    logic [SEQ_BITS-1:0] r_oseq,   n_oseq;
    logic [TAG_BITS-1:0] r_otag,   n_otag;

    logic                is_full;
    logic                is_empty;
    logic [IDX_W-1:0]    cnt_idx;
    logic [SEQ_BITS-1:0] rd_seq;
    logic [TAG_BITS-1:0] rd_tag;

    assign is_full  = (r_count == CAP_CNT);
    assign is_empty = (r_count == '0);
    // Only used when the queue is neither full nor empty, so the count fits an index.
    assign cnt_idx  = r_count[IDX_W-1:0];
    assign rd_seq   = i_mem_rd_data[SEQ_BITS+TAG_BITS-1:TAG_BITS];
    assign rd_tag   = i_mem_rd_data[TAG_BITS-1:0];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_head        = r_head;
        n_walk        = r_walk;
        n_seq         = r_seq;
        n_tag         = r_tag;
        n_op          = r_op;
        n_status      = r_status;
        n_oseq        = r_oseq;
        n_otag        = r_otag;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_head;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_head;
        o_mem_wr_data = {r_seq, r_tag};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_seq    = i_item_seq;
                    n_tag    = i_item_tag;
                    n_op     = i_op;
                    n_status = ST_OK;
                    n_oseq   = '0;
                    n_otag   = '0;
                    n_state  = S_FIN;
                    if (i_op == OP_PUSH) begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else if (is_empty) begin
                            o_mem_wr_en   = 1'b1;
                            o_mem_wr_addr = r_head;
                            o_mem_wr_data = {i_item_seq, i_item_tag};
                            n_count       = r_count + CNT_W'(1);
                        end else begin
                            // Start the walk at the tail entry.
                            o_mem_rd_en   = 1'b1;
                            o_mem_rd_addr = slot_addr(r_head, cnt_idx - IDX_W'(1));
                            n_walk        = cnt_idx - IDX_W'(1);
                            n_state       = S_PUSH;
                        end
                    end else if (i_op inside {OP_POP, OP_PEEK}) begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_mem_rd_en   = 1'b1;
                            o_mem_rd_addr = r_head;
                            n_state       = S_HEAD;
                        end
                    end
                end
            end
            S_PUSH: begin
                // Entry at r_walk is on the read port. Equal or higher numbers move back
                // one slot; the read of the next lower position is issued in the same cycle.
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = slot_addr(r_head, r_walk + IDX_W'(1));
                if (rd_seq >= r_seq) begin
                    o_mem_wr_data = i_mem_rd_data;
                    if (r_walk == '0) begin
                        n_state = S_INS;
                    end else begin
                        o_mem_rd_en   = 1'b1;
                        o_mem_rd_addr = slot_addr(r_head, r_walk - IDX_W'(1));
                        n_walk        = r_walk - IDX_W'(1);
                    end
                end else begin
                    o_mem_wr_data = {r_seq, r_tag};
                    n_count       = r_count + CNT_W'(1);
                    n_state       = S_FIN;
                end
            end
            S_INS: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_head;
                o_mem_wr_data = {r_seq, r_tag};
                n_count       = r_count + CNT_W'(1);
                n_state       = S_FIN;
            end
            S_HEAD: begin
                n_oseq = rd_seq;
                n_otag = rd_tag;
                if (r_op == OP_POP) begin
                    n_head  = slot_addr(r_head, IDX_W'(1));
                    n_count = r_count - CNT_W'(1);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_seq    <= n_seq;
        r_tag    <= n_tag;
        r_op     <= n_op;
        r_status <= n_status;
        r_oseq   <= n_oseq;
        r_otag   <= n_otag;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_FIN);
    assign o_res_status = r_status;
    assign o_res_seq    = r_oseq;
    assign o_res_tag    = r_otag;
    assign o_res_count  = r_count;

endmodule

>>> bench/tb_sequence_ordered_packet_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sequence-ordered packet queue with its own ordered-store predictor.
module tb_sequence_ordered_packet_queue;
    import soq_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;
    localparam int SW = SEQ_BITS_DEF;
    localparam int TW = TAG_BITS_DEF;
    localparam int CW = $clog2(DEPTH + 1);
    localparam t_op OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int MAX_REPORTS = 10;
    localparam int MAX_GAP = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_status       status;
        logic [SW-1:0] seq;
        logic [TW-1:0] tag;
        logic [CW-1:0] count;
    } t_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    t_op           i_op = OP_PUSH;
    logic [SW-1:0] i_item_seq = '0;
    logic [TW-1:0] i_item_tag = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    t_status       o_status;
    logic [SW-1:0] o_out_seq;
    logic [TW-1:0] o_out_tag;
    logic [CW-1:0] o_count;

    // Mirror of the ordered store, head at index zero.
    logic [SW-1:0] mirror_seq [DEPTH];
    logic [TW-1:0] mirror_tag [DEPTH];
    int            mirror_count = 0;

    t_result       expected_results [$];
    t_result       oldest_result;
    int            failures = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    logic          rx_hold = 1'b0;

    sequence_ordered_packet_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_item_seq  (i_item_seq),
        .i_item_tag  (i_item_tag),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_out_seq   (o_out_seq),
        .o_out_tag   (o_out_tag),
        .o_count     (o_count)
    );

    always #5 i_clk = ~i_clk;

    // Applies one request to the mirror and returns the result the queue must give.
    function automatic t_result predict_queue_result(input t_op op, input logic [SW-1:0] seq,
                                                     input logic [TW-1:0] tag);
        t_result r;
        int      pos;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (mirror_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // Entries with an equal or higher number move back, so the new one
                    // lands ahead of any equal numbers.
                    pos = mirror_count;
                    while (pos > 0 && mirror_seq[pos-1] >= seq) begin
                        mirror_seq[pos] = mirror_seq[pos-1];
                        mirror_tag[pos] = mirror_tag[pos-1];
                        pos--;
                    end
                    mirror_seq[pos] = seq;
                    mirror_tag[pos] = tag;
                    mirror_count++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.seq = mirror_seq[0];
                    r.tag = mirror_tag[0];
                    if (op == OP_POP) begin
                        for (pos = 1; pos < mirror_count; pos++) begin
                            mirror_seq[pos-1] = mirror_seq[pos];
                            mirror_tag[pos-1] = mirror_tag[pos];
                        end
                        mirror_count--;
                    end
                end
            end
            default: ;
        endcase
        r.count = CW'(mirror_count);
        return r;
    endfunction

    // Offers one request after a random gap and holds it until it is accepted.
    task automatic send_request(input t_op op, input logic [SW-1:0] seq,
                                input logic [TW-1:0] tag);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_item_seq <= seq;
        i_item_tag <= tag;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_queue_result(op, seq, tag));
    endtask

    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        send_request(OP_PEEK, '0, '0);
        send_request(OP_POP, '1, '1);
        send_request(OP_UNUSED, 16'h1234, 16'h5678);
        send_request(OP_PUSH, 16'hFFFF, 16'h0000);
        send_request(OP_PUSH, 16'h0000, 16'hFFFF);
        send_request(OP_PUSH, 16'h8000, 16'h0001);
        // The second request with an equal number must sit ahead of the first.
        send_request(OP_PUSH, 16'h8000, 16'h0002);
        send_request(OP_PEEK, '1, '1);
        send_request(OP_UNUSED, '1, '1);
        repeat (DEPTH - 4) send_request(OP_PUSH, SW'($urandom), TW'($urandom));
        send_request(OP_PUSH, 16'h0001, 16'hBEEF);
        send_request(OP_PEEK, '0, '0);
        send_request(OP_POP, '0, '0);
    endtask

    // Mixed traffic whose push share drifts so that the fill level sweeps empty to full.
    task automatic test_random_traffic(input int items, input int tx_pct, input int rx_pct);
        int            n;
        int            push_pct;
        t_op           op;
        logic [SW-1:0] seq;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        push_pct = 50;
        for (n = 0; n < items; n++) begin
            if (n % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if ($urandom_range(0, 99) < 5) op = OP_UNUSED;
            else if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
            else if ($urandom_range(0, 3) == 0) op = OP_PEEK;
            else op = OP_POP;
            // A narrow range of numbers produces many ties.
            case ($urandom_range(0, 3))
                0:       seq = SW'($urandom_range(0, 7));
                1:       seq = $urandom_range(0, 1) ? '1 : '0;
                default: seq = SW'($urandom);
            endcase
            send_request(op, seq, TW'($urandom));
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure_fill();
        int n;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (n = 0; n < 48; n++) begin
            send_request($urandom_range(0, 2) != 0 ? OP_PUSH : OP_POP,
                         SW'($urandom), TW'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("unexpected result: status %0d seq %h tag %h count %0d",
                             o_status, o_out_seq, o_out_tag, o_count);
                end
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_status !== oldest_result.status || o_out_seq !== oldest_result.seq ||
                    o_out_tag !== oldest_result.tag || o_count !== oldest_result.count) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("mismatch at %0t: status %0d/%0d seq %h/%h tag %h/%h count %0d/%0d",
                                 $realtime, oldest_result.status, o_status,
                                 oldest_result.seq, o_out_seq, oldest_result.tag, o_out_tag,
                                 oldest_result.count, o_count);
                        $display("    (expected/actual)");
                    end
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic(500, 15, 86);
        test_random_traffic(500, 86, 15);
        test_backpressure_fill();
        test_random_traffic(500, 0, 0);
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("** sequence_ordered_packet_queue: PASSED **");
        end else begin
            $display("** sequence_ordered_packet_queue: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** sequence_ordered_packet_queue: FAILED **");
        $finish;
    end

endmodule

>>> sequence_ordered_packet_queue.f
+incdir+sv
sv/soq_pkg.sv
sv/soq_mem.sv
sv/soq_ctrl.sv
sv/sequence_ordered_packet_queue.sv
bench/tb_sequence_ordered_packet_queue.sv
